// ===== src/urlencoded_pair_segmenter_defines.svh =====
// Assertion macros for the urlencoded pair segmenter
`ifndef URLENCODED_PAIR_SEGMENTER_DEFINES_SVH
`define URLENCODED_PAIR_SEGMENTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ups_pkg.sv =====
// Shared types and constants for the urlencoded pair segmenter
package ups_pkg;

  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_AMP = 8'h26;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NAME_LONG = 3'd1;
  localparam logic [2:0] ERR_VAL_LONG  = 3'd2;
  localparam logic [2:0] ERR_TRAILING  = 3'd3;
  localparam logic [2:0] ERR_STUCK     = 3'd4;

  localparam logic REG_MAX_TOKEN_LEN = 1'b0;
  localparam logic REG_BUFFERED_MODE = 1'b1;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_EQ    = 2'd1,
    CLS_AMP   = 2'd2,
    CLS_EOB   = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  byte_kind;
    logic        tuple_start;
    logic        tuple_done;
    logic        had_value;
    logic [15:0] name_length;
    logic [15:0] value_length;
    logic [2:0]  error_code;
  } res_t;

endpackage

// ===== src/urlencoded_pair_segmenter.sv =====
// Top level of the urlencoded pair segmenter.
// Takes a form body one byte per transaction (in_tuser high marks end of
// body) and returns one result transaction per input: the byte, its kind,
// tuple start/done flags, name and value lengths and an error code. It
// sustains one transaction per cycle while the output is not stalled; an
// input passes through the two-entry classifier queue and then the
// parser's output register before its result appears. Errors are sticky
// until reset. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
`include "urlencoded_pair_segmenter_defines.svh"
module urlencoded_pair_segmenter
  import ups_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_out, [8] tuple_start, [9] tuple_done, [10] had_value,
  // [26:11] name_length, [42:27] value_length, [45:43] error_code
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] byte_kind
);

  logic [15:0] max_token_len_r;
  logic        buffered_mode_r;
  qstat_t      q_stat;
  logic        push, pop;
  item_t       push_item, head;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_token_len_r <= 16'd4096;
      buffered_mode_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MAX_TOKEN_LEN) begin
        max_token_len_r <= cfg_wdata;
      end
      if (cfg_addr == REG_BUFFERED_MODE) begin
        buffered_mode_r <= cfg_wdata[0];
      end
    end
  end

  ups_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  ups_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ups_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .max_token_len (max_token_len_r),
    .buffered_mode (buffered_mode_r),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  assign out_tdata = {2'b00, res.error_code, res.value_length, res.name_length,
                      res.had_value, res.tuple_done, res.tuple_start, res.byte_out};
  assign out_tuser = res.byte_kind;

  `UPS_ASSERT_NOW(a_done_no_err, out_tvalid && res.tuple_done, res.error_code == ERR_NONE, "tuple done with error")
  `UPS_ASSERT_NOW(a_start_no_err, out_tvalid && res.tuple_start, res.error_code == ERR_NONE, "tuple start with error")
  `UPS_ASSERT_NOW(a_hv_needs_done, out_tvalid && res.had_value, res.tuple_done, "had_value without tuple_done")
  `UPS_ASSERT_NEXT(a_full_stalls, q_stat.full && !pop, !in_tready, "queue full but input ready")

endmodule

// ===== src/ups_front.sv =====
// Front end: accepts input transactions and classifies each byte
module ups_front
  import ups_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  qstat_t     q_stat,
  output logic       push,
  output item_t      item
);

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    item.data = in_tdata;
    if (in_tuser) begin
      item.cls  = CLS_EOB;
      item.data = 8'd0;
    end else if (in_tdata == CH_EQ) begin
      item.cls = CLS_EQ;
    end else if (in_tdata == CH_AMP) begin
      item.cls = CLS_AMP;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

endmodule

// ===== src/ups_queue.sv =====
// Two-entry queue between the classifier and the parser
module ups_queue
  import ups_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t q_stat
);

  item_t      mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.valid = (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/ups_back.sv =====
// Back end: tuple parser state machine and output register
module ups_back
  import ups_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  qstat_t      q_stat,
  input  item_t       head,
  output logic        pop,
  input  logic [15:0] max_token_len,
  input  logic        buffered_mode,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

  typedef enum logic [2:0] {
    PH_NAME_START  = 3'd0,
    PH_NAME        = 3'd1,
    PH_VALUE_START = 3'd2,
    PH_VALUE       = 3'd3,
    PH_END         = 3'd4,
    PH_ERROR       = 3'd5
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                seen_name_r, seen_name_nxt;
  logic                seen_value_r, seen_value_nxt;
  logic [LEN_BITS-1:0] name_cnt_r, name_cnt_nxt;
  logic [LEN_BITS-1:0] value_cnt_r, value_cnt_nxt;
  logic                res_valid_r, res_valid_nxt;
  res_t                res_r, res_nxt;

  logic                eob, is_amp, is_eq, buf_mode;
  logic [CMP_W-1:0]    max_ext, name_ext, value_ext;

  assign pop       = q_stat.valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign eob      = (head.cls == CLS_EOB);
  assign is_amp   = (head.cls == CLS_AMP);
  assign is_eq    = (head.cls == CLS_EQ);
  assign buf_mode = buffered_mode;
  assign max_ext  = CMP_W'(max_token_len);

  always_comb begin
    phase_nxt      = phase_r;
    seen_name_nxt  = seen_name_r;
    seen_value_nxt = seen_value_r;
    name_cnt_nxt   = name_cnt_r;
    value_cnt_nxt  = value_cnt_r;

    res_nxt              = '0;
    res_nxt.byte_out     = head.data;
    res_nxt.byte_kind    = KIND_NONE;
    res_nxt.error_code   = ERR_NONE;

    if (phase_nxt == PH_NAME_START) begin
      res_nxt.tuple_start = 1'b1;
      seen_name_nxt       = 1'b0;
      seen_value_nxt      = 1'b0;
      name_cnt_nxt        = '0;
      value_cnt_nxt       = '0;
      phase_nxt           = PH_NAME;
    end
    if (phase_nxt == PH_VALUE_START) begin
      seen_value_nxt = 1'b1;
      value_cnt_nxt  = '0;
      phase_nxt      = PH_VALUE;
    end

    name_ext  = CMP_W'(name_cnt_nxt);
    value_ext = CMP_W'(value_cnt_nxt);

    case (phase_nxt)
      PH_NAME: begin
        if (eob || is_eq || is_amp) begin
          if (buf_mode && (name_ext > max_ext)) begin
            res_nxt.error_code = ERR_NAME_LONG;
            phase_nxt          = PH_ERROR;
          end else begin
            if ((eob || is_amp) && (!buf_mode || seen_name_nxt)) begin
              res_nxt.tuple_done  = 1'b1;
              res_nxt.name_length = name_ext[15:0];
            end
            if (eob) begin
              phase_nxt = PH_END;
            end else if (is_eq) begin
              phase_nxt = PH_VALUE_START;
            end else begin
              phase_nxt = PH_NAME_START;
            end
          end
        end else begin
          res_nxt.byte_kind = KIND_NAME;
          seen_name_nxt     = 1'b1;
          if (name_cnt_nxt != '1) begin
            name_cnt_nxt = name_cnt_nxt + 1'b1;
          end
        end
      end
      PH_VALUE: begin
        if (eob || is_amp) begin
          if (buf_mode && (value_ext > max_ext)) begin
            res_nxt.error_code = ERR_VAL_LONG;
            phase_nxt          = PH_ERROR;
          end else begin
            if (!buf_mode || seen_name_nxt) begin
              res_nxt.tuple_done   = 1'b1;
              res_nxt.had_value    = seen_value_nxt;
              res_nxt.name_length  = name_ext[15:0];
              res_nxt.value_length = value_ext[15:0];
            end
            phase_nxt = eob ? PH_END : PH_NAME_START;
          end
        end else begin
          res_nxt.byte_kind = KIND_VALUE;
          if (value_cnt_nxt != '1) begin
            value_cnt_nxt = value_cnt_nxt + 1'b1;
          end
        end
      end
      PH_END: begin
        if (!eob) begin
          res_nxt.error_code = ERR_TRAILING;
          phase_nxt          = PH_ERROR;
        end
      end
      default: begin
        res_nxt.error_code = ERR_STUCK;
        phase_nxt          = PH_ERROR;
      end
    endcase

    res_valid_nxt = pop || (res_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NAME_START;
      seen_name_r  <= 1'b0;
      seen_value_r <= 1'b0;
      name_cnt_r   <= '0;
      value_cnt_r  <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (pop) begin
        phase_r      <= phase_nxt;
        seen_name_r  <= seen_name_nxt;
        seen_value_r <= seen_value_nxt;
        name_cnt_r   <= name_cnt_nxt;
        value_cnt_r  <= value_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for urlencoded_pair_segmenter: stream driver, monitor, parser predictor
module testbench;
  import ups_pkg::*;

  typedef enum logic [2:0] {
    ST_NAME_START  = 3'd0,
    ST_NAME        = 3'd1,
    ST_VALUE_START = 3'd2,
    ST_VALUE       = 3'd3,
    ST_END         = 3'd4,
    ST_ERROR       = 3'd5
  } parse_state_e;

  typedef struct packed {
    logic       eob;
    logic [7:0] data;
  } body_item_t;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] byte_in
  logic        in_tuser = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] byte_out, [8] tuple_start, [9] tuple_done, [10] had_value,
  // [26:11] name_length, [42:27] value_length, [45:43] error_code
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;       // [1:0] byte_kind

  urlencoded_pair_segmenter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // parser model state and its copy of the registers
  parse_state_e ph;
  logic         got_name;
  logic         got_value;
  logic [15:0]  name_cnt;
  logic [15:0]  value_cnt;
  logic [15:0]  tok_limit;
  logic         buf_mode_q;

  body_item_t body_q[$];
  res_t       expect_q[$];
  int         n_pushed = 0;
  int         n_taken = 0;
  int         n_errors = 0;
  int         hold_req = 0;

  function automatic res_t parse_step(input logic eob, input logic [7:0] c);
    res_t r;
    r = '0;
    r.byte_out = eob ? 8'h00 : c;
    r.byte_kind = KIND_NONE;
    r.error_code = ERR_NONE;
    if (ph == ST_NAME_START) begin
      r.tuple_start = 1'b1;
      got_name = 1'b0;
      got_value = 1'b0;
      name_cnt = '0;
      value_cnt = '0;
      ph = ST_NAME;
    end
    if (ph == ST_VALUE_START) begin
      got_value = 1'b1;
      value_cnt = '0;
      ph = ST_VALUE;
    end
    case (ph)
      ST_NAME: begin
        if (eob || c == CH_EQ || c == CH_AMP) begin
          if (buf_mode_q && name_cnt > tok_limit) begin
            r.error_code = ERR_NAME_LONG;
            ph = ST_ERROR;
          end else begin
            if ((eob || c == CH_AMP) && (!buf_mode_q || got_name)) begin
              r.tuple_done = 1'b1;
              r.name_length = name_cnt;
            end
            if (eob) ph = ST_END;
            else if (c == CH_EQ) ph = ST_VALUE_START;
            else ph = ST_NAME_START;
          end
        end else begin
          r.byte_kind = KIND_NAME;
          got_name = 1'b1;
          if (name_cnt != 16'hFFFF) name_cnt = name_cnt + 16'd1;
        end
      end
      ST_VALUE: begin
        if (eob || c == CH_AMP) begin
          if (buf_mode_q && value_cnt > tok_limit) begin
            r.error_code = ERR_VAL_LONG;
            ph = ST_ERROR;
          end else begin
            if (!buf_mode_q || got_name) begin
              r.tuple_done = 1'b1;
              r.had_value = got_value;
              r.name_length = name_cnt;
              r.value_length = value_cnt;
            end
            ph = eob ? ST_END : ST_NAME_START;
          end
        end else begin
          r.byte_kind = KIND_VALUE;
          if (value_cnt != 16'hFFFF) value_cnt = value_cnt + 16'd1;
        end
      end
      ST_END: begin
        if (!eob) begin
          r.error_code = ERR_TRAILING;
          ph = ST_ERROR;
        end
      end
      default: begin
        r.error_code = ERR_STUCK;
        ph = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;
  body_item_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expect_q.push_back(parse_step(in_tuser, in_tdata));
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (body_q.size() != 0) begin
          nxt = body_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tuser <= nxt.eob;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changing per segment, plus requested long hold-offs
  int hold_ack = 0;
  int hold_left = 0;
  int seg_left = 0;
  int rx_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 200);
      end else begin
        seg_left--;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      n_errors++;
    end
  endfunction

  res_t got_r;
  res_t want_r;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r.byte_out     = out_tdata[7:0];
      got_r.byte_kind    = out_tuser;
      got_r.tuple_start  = out_tdata[8];
      got_r.tuple_done   = out_tdata[9];
      got_r.had_value    = out_tdata[10];
      got_r.name_length  = out_tdata[26:11];
      got_r.value_length = out_tdata[42:27];
      got_r.error_code   = out_tdata[45:43];
      if (expect_q.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", out_tdata);
        n_errors++;
      end else begin
        want_r = expect_q.pop_front();
        check_field("byte_out", 16'(want_r.byte_out), 16'(got_r.byte_out));
        check_field("byte_kind", 16'(want_r.byte_kind), 16'(got_r.byte_kind));
        check_field("tuple_start", 16'(want_r.tuple_start), 16'(got_r.tuple_start));
        check_field("tuple_done", 16'(want_r.tuple_done), 16'(got_r.tuple_done));
        check_field("had_value", 16'(want_r.had_value), 16'(got_r.had_value));
        check_field("name_length", want_r.name_length, got_r.name_length);
        check_field("value_length", want_r.value_length, got_r.value_length);
        check_field("error_code", 16'(want_r.error_code), 16'(got_r.error_code));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic void push_item(input logic eob, input logic [7:0] d);
    body_item_t it;
    it.eob = eob;
    it.data = d;
    body_q.push_back(it);
    n_pushed++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_EQ || c == CH_AMP);
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_AMP);
    return c;
  endfunction

  function automatic void push_name(input int n);
    for (int i = 0; i < n; i++) push_item(1'b0, name_char());
  endfunction

  function automatic void push_value(input int n);
    for (int i = 0; i < n; i++) push_item(1'b0, value_char());
  endfunction

  // one tuple that stays within the current length limit, or a noise run
  function automatic void push_random_segment();
    int cap;
    int n;
    int sel;
    cap = 10;
    if (buf_mode_q && tok_limit < 10) cap = int'(tok_limit);
    if ((!buf_mode_q || tok_limit >= 64) && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 3);
        if (sel == 0) push_item(1'b0, CH_EQ);
        else if (sel == 1) push_item(1'b0, CH_AMP);
        else push_item(1'b0, 8'($urandom_range(0, 255)));
      end
      push_item(1'b0, CH_AMP);
    end else begin
      push_name(($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, cap)));
      if ($urandom_range(0, 3) != 0) begin
        push_item(1'b0, CH_EQ);
        push_value(int'($urandom_range(0, cap)));
      end
      push_item(1'b0, CH_AMP);
    end
  endfunction

  function automatic void fill_random(input int count);
    int stop;
    stop = n_pushed + count;
    while (n_pushed < stop) push_random_segment();
  endfunction

  task automatic wait_drain();
    do @(negedge clk); while (!(n_taken == n_pushed && expect_q.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_TOKEN_LEN) tok_limit = val;
    else buf_mode_q = val[0];
    @(negedge clk);
  endtask

  int ending;
  int lim;

  initial begin
    ph = ST_NAME_START;
    got_name = 1'b0;
    got_value = 1'b0;
    name_cnt = '0;
    value_cnt = '0;
    tok_limit = 16'd4096;
    buf_mode_q = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: empty tuples, bare '=', '=' inside a value, byte extremes
    push_text("&");
    push_text("=&");
    push_text("a&");
    push_text("b=&");
    push_text("ab=c=d&");
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, CH_EQ);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h00);
    push_item(1'b0, CH_AMP);
    fill_random(60);
    wait_drain();

    write_reg(REG_MAX_TOKEN_LEN, 16'd1);
    write_reg(REG_BUFFERED_MODE, 16'd1);
    push_text("x=y&");
    push_text("=&");
    fill_random(60);
    wait_drain();

    // unbuffered: empty names reported, no length check, long name
    write_reg(REG_MAX_TOKEN_LEN, 16'hFFFF);
    write_reg(REG_BUFFERED_MODE, 16'd0);
    push_text("&");
    push_text("=v&");
    push_text("k&");
    push_name(40);
    push_item(1'b0, CH_AMP);
    fill_random(60);
    wait_drain();

    write_reg(REG_MAX_TOKEN_LEN, 16'($urandom_range(2, 12)));
    write_reg(REG_BUFFERED_MODE, 16'd1);
    @(negedge clk);
    hold_req++;
    fill_random(150);
    wait_drain();

    write_reg(REG_BUFFERED_MODE, 16'd0);
    fill_random(80);
    wait_drain();

    // closing part: one way into the sticky error state
    lim = $urandom_range(1, 6);
    write_reg(REG_MAX_TOKEN_LEN, 16'(lim));
    write_reg(REG_BUFFERED_MODE, 16'd1);
    ending = $urandom_range(0, 2);
    if (ending == 0) begin
      push_name(lim + 1);
      case ($urandom_range(0, 2))
        0: push_item(1'b0, CH_AMP);
        1: push_item(1'b0, CH_EQ);
        default: push_item(1'b1, 8'($urandom_range(0, 255)));
      endcase
    end else if (ending == 1) begin
      push_name(1);
      push_item(1'b0, CH_EQ);
      push_value(lim + 1);
      if ($urandom_range(0, 1) != 0) push_item(1'b0, CH_AMP);
      else push_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1) != 0) begin
        push_name(int'($urandom_range(0, lim)));
        if ($urandom_range(0, 1) != 0) begin
          push_item(1'b0, CH_EQ);
          push_value(int'($urandom_range(0, lim)));
        end
      end
      push_item(1'b1, 8'($urandom_range(0, 255)));
      for (int i = int'($urandom_range(0, 2)); i > 0; i--) begin
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end
      push_item(1'b0, 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < 10; i++) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    wait_drain();
    repeat (10) @(posedge clk);

    if (expect_q.size() != 0) begin
      $error("%0d expected results never arrived", expect_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ups_pkg.sv
src/ups_front.sv
src/ups_queue.sv
src/ups_back.sv
src/urlencoded_pair_segmenter.sv
bench/testbench.sv
